// ===== rtl/clntw_pkg.sv =====
// Package for the character LCD nibble text writer.
// Holds the configuration, job and cursor types, codes and the cursor function.
// No dependencies.
`timescale 1ns / 1ps

package clntw_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_LINE_COUNT   = 2'd1,
    REG_WRAP_ENABLE  = 2'd2,
    REG_BACKLIGHT_ON = 2'd3
  } reg_idx_t;

  localparam logic [5:0] LINE_WIDTH_RST   = 6'd16;
  localparam logic [2:0] LINE_COUNT_RST   = 3'd2;
  localparam logic       WRAP_ENABLE_RST  = 1'b1;
  localparam logic       BACKLIGHT_ON_RST = 1'b1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_FF = 8'h0C;

  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] CMD_DDRAM  = 8'h80;
  localparam logic [7:0] ROW0_BASE  = 8'h00;
  localparam logic [7:0] ROW1_BASE  = 8'h40;
  localparam logic [7:0] ROW2_BASE  = 8'h14;
  localparam logic [7:0] ROW3_BASE  = 8'h54;
  localparam logic [7:0] ROWS_ADDRESSED = 8'd4;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  typedef struct packed {
    logic [5:0] line_width;
    logic [2:0] line_count;
    logic       wrap_enable;
    logic       backlight_on;
  } cfg_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic       first_rs;
    logic       has_second;
    logic [7:0] second_byte;
  } job_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       has_cmd;
    logic [7:0] cmd;
  } cursor_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
  } front_status_t;

  function automatic cursor_t set_cursor(logic [7:0] x, logic [7:0] y, cfg_t cfg);
    cursor_t    r;
    logic [7:0] base;
    r.col = x;
    r.row = y;
    if (cfg.wrap_enable) begin
      if (x >= {2'b00, cfg.line_width}) r.col = 8'd0;
      if (y >= {5'b00000, cfg.line_count}) r.row = 8'd0;
    end
    case (r.row)
      8'd0:    base = ROW0_BASE;
      8'd1:    base = ROW1_BASE;
      8'd2:    base = ROW2_BASE;
      8'd3:    base = ROW3_BASE;
      default: base = ROW0_BASE;
    endcase
    r.has_cmd = (r.row < ROWS_ADDRESSED);
    r.cmd     = (base + r.col) | CMD_DDRAM;
    return r;
  endfunction

endpackage

// ===== rtl/char_lcd_nibble_text_writer_top.sv =====
// Top level of the character LCD nibble text writer.
// Holds the configuration registers; instantiates clntw_front, clntw_queue, clntw_back.
// Depends on clntw_pkg.
//
//   channel  ports                                   accepted when
//   input    in_push, in_full, in_char_code          in_push && !in_full
//   result   out_pop, out_empty, out_bus_byte,       out_pop && !out_empty
//            out_last_of_run
//   config   cfg_we, cfg_index, cfg_wdata            cfg_we
//
// A character yields 0, 4 or 8 bus bytes; the back-end sequencer sends one per cycle while
// the output slot is free, so a printed character yields 4, or 8 when it wraps onto an addressed row.
// Characters enter one per cycle while the job queue (QUEUE_DEPTH jobs) has room.
// A dequeued job is registered in job_r, then each of its bus bytes in out_byte_r.
// Synchronous active-low reset; configuration returns to 16 columns, 2 lines,
// wrap on, backlight on, cursor at the origin.
`timescale 1ns / 1ps

module char_lcd_nibble_text_writer_top #(
  parameter int QUEUE_DEPTH = clntw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [7:0]                       in_char_code,
  input  logic                             out_pop,
  output logic                             out_empty,
  output logic [7:0]                       out_bus_byte,
  output logic                             out_last_of_run,
  input  logic                             cfg_we,
  input  logic [clntw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clntw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  clntw_pkg::cfg_t          cfg_r, cfg_nxt;
  logic                     in_accept;
  logic                     job_valid;
  clntw_pkg::job_t          job;
  clntw_pkg::job_t          q_rdata;
  logic                     q_full, q_empty, q_rd;
  clntw_pkg::front_status_t status;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (clntw_pkg::reg_idx_t'(cfg_index))
        clntw_pkg::REG_LINE_WIDTH:   cfg_nxt.line_width   = cfg_wdata[5:0];
        clntw_pkg::REG_LINE_COUNT:   cfg_nxt.line_count   = cfg_wdata[2:0];
        clntw_pkg::REG_WRAP_ENABLE:  cfg_nxt.wrap_enable  = cfg_wdata[0];
        clntw_pkg::REG_BACKLIGHT_ON: cfg_nxt.backlight_on = cfg_wdata[0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_width   <= clntw_pkg::LINE_WIDTH_RST;
      cfg_r.line_count   <= clntw_pkg::LINE_COUNT_RST;
      cfg_r.wrap_enable  <= clntw_pkg::WRAP_ENABLE_RST;
      cfg_r.backlight_on <= clntw_pkg::BACKLIGHT_ON_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  clntw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (in_accept),
    .char_code (in_char_code),
    .job_valid (job_valid),
    .job       (job),
    .status    (status)
  );

  clntw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (job_valid),
    .wdata (job),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  clntw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .backlight_on    (cfg_r.backlight_on),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_rd            (q_rd),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_bus_byte    (out_bus_byte),
    .out_last_of_run (out_last_of_run)
  );

  a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_char_code == clntw_pkg::CHAR_FF) |=>
      (status.col == 8'd0 && status.row == 8'd0))
    else $error("form feed did not home the cursor");

  a_wrap_clamps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && cfg_r.wrap_enable) |=>
      (status.col < {2'b00, $past(cfg_r.line_width)} || status.col == 8'd0))
    else $error("cursor column past line end with wrap on");

  a_last_on_strobe_low: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last_of_run) |-> !out_bus_byte[2])
    else $error("run ends on a byte with enable high");

  a_strobe_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_bus_byte[2]) |-> !out_last_of_run)
    else $error("enable-high byte marked as last");

endmodule

// ===== rtl/clntw_front.sv =====
// Front end: classifies each character, tracks the cursor, builds byte jobs.
// Depends on clntw_pkg.
`timescale 1ns / 1ps

module clntw_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  clntw_pkg::cfg_t          cfg,
  input  logic                     accept,
  input  logic [7:0]               char_code,
  output logic                     job_valid,
  output clntw_pkg::job_t          job,
  output clntw_pkg::front_status_t status
);

  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;
  logic [7:0] col_inc, row_inc, row_wrap;
  logic       wrap_hit;
  clntw_pkg::cursor_t cr_cur, lf_cur, pr_cur;

  always_comb begin
    col_inc  = col_r + 8'd1;
    row_inc  = row_r + 8'd1;
    row_wrap = (row_inc >= {5'b00000, cfg.line_count}) ? 8'd0 : row_inc;
    wrap_hit = cfg.wrap_enable && (col_inc >= {2'b00, cfg.line_width});
    cr_cur   = clntw_pkg::set_cursor(8'd0, row_r, cfg);
    lf_cur   = clntw_pkg::set_cursor(col_r, row_inc, cfg);
    pr_cur   = clntw_pkg::set_cursor(8'd0, row_wrap, cfg);

    col_nxt   = col_r;
    row_nxt   = row_r;
    job_valid = 1'b0;
    job       = '0;
    if (accept) begin
      case (char_code)
        clntw_pkg::CHAR_CR: begin
          col_nxt        = cr_cur.col;
          row_nxt        = cr_cur.row;
          job_valid      = cr_cur.has_cmd;
          job.first_byte = cr_cur.cmd;
          job.first_rs   = clntw_pkg::RS_CMD;
        end
        clntw_pkg::CHAR_LF: begin
          col_nxt        = lf_cur.col;
          row_nxt        = lf_cur.row;
          job_valid      = lf_cur.has_cmd;
          job.first_byte = lf_cur.cmd;
          job.first_rs   = clntw_pkg::RS_CMD;
        end
        clntw_pkg::CHAR_FF: begin
          col_nxt        = 8'd0;
          row_nxt        = 8'd0;
          job_valid      = 1'b1;
          job.first_byte = clntw_pkg::CMD_CLEAR;
          job.first_rs   = clntw_pkg::RS_CMD;
        end
        default: begin
          job_valid      = 1'b1;
          job.first_byte = char_code;
          job.first_rs   = clntw_pkg::RS_DATA;
          if (wrap_hit) begin
            col_nxt         = pr_cur.col;
            row_nxt         = pr_cur.row;
            job.has_second  = pr_cur.has_cmd;
            job.second_byte = pr_cur.cmd;
          end else begin
            col_nxt = col_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 8'd0;
      row_r <= 8'd0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign status.col = col_r;
  assign status.row = row_r;

endmodule

// ===== rtl/clntw_queue.sv =====
// Job queue between front and back end.
// Depends on clntw_pkg.
`timescale 1ns / 1ps

module clntw_queue #(
  parameter int DEPTH = clntw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  clntw_pkg::job_t wdata,
  input  logic            rd,
  output clntw_pkg::job_t rdata,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  clntw_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (wr) wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    if (rd) rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    if (wr && !rd) count_nxt = count_r + 1'b1;
    else if (rd && !wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr_r] <= wdata;
  end

  assign rdata = mem[rptr_r];
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

endmodule

// ===== rtl/clntw_back.sv =====
// Back end: sequences each job into expander bus bytes, one per cycle while the output slot is free.
// Depends on clntw_pkg.
`timescale 1ns / 1ps

module clntw_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            backlight_on,
  input  logic            q_empty,
  input  clntw_pkg::job_t q_rdata,
  output logic            q_rd,
  input  logic            out_pop,
  output logic            out_empty,
  output logic [7:0]      out_bus_byte,
  output logic            out_last_of_run
);

  logic            busy_r, busy_nxt;
  logic [2:0]      step_r, step_nxt;
  clntw_pkg::job_t job_r;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r;
  logic            out_last_r;
  logic            slot_free, emit, last_step, done, load;
  logic [7:0]      cur_byte;
  logic [3:0]      nib;
  logic            rs;
  logic [7:0]      bus;

  always_comb begin
    slot_free = !out_valid_r || out_pop;
    emit      = busy_r && slot_free;
    last_step = (step_r == 3'd3 && !job_r.has_second) || (step_r == 3'd7);
    done      = emit && last_step;
    load      = (!busy_r || done) && !q_empty;
    q_rd      = load;

    cur_byte = step_r[2] ? job_r.second_byte : job_r.first_byte;
    nib      = step_r[1] ? cur_byte[3:0] : cur_byte[7:4];
    rs       = step_r[2] ? clntw_pkg::RS_CMD : job_r.first_rs;
    bus      = {nib, backlight_on, !step_r[0], 1'b0, rs};

    if (emit) out_valid_nxt = 1'b1;
    else if (out_pop) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;

    if (load) busy_nxt = 1'b1;
    else if (done) busy_nxt = 1'b0;
    else busy_nxt = busy_r;

    if (load) step_nxt = 3'd0;
    else if (emit) step_nxt = step_r + 3'd1;
    else step_nxt = step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) job_r <= q_rdata;
    if (emit) begin
      out_byte_r <= bus;
      out_last_r <= last_step;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_bus_byte    = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== test/char_lcd_nibble_text_writer_top_tb.sv =====
// Testbench for char_lcd_nibble_text_writer_top: runs directed and random character streams
// under several display geometries and checks every bus byte against a cursor-tracking predictor.
// Depends on clntw_pkg and the RTL of the text writer.
`timescale 1ns / 1ps

module char_lcd_nibble_text_writer_top_tb;

  localparam logic [7:0] LCD_EN = 8'h04;
  localparam int SETTLE_CYCLES = 48;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       last_of_run;
  } lcd_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [7:0]            in_char_code;
  logic                  out_pop;
  logic                  out_empty;
  logic [7:0]            out_bus_byte;
  logic                  out_last_of_run;
  logic                  cfg_we;
  clntw_pkg::reg_idx_t   cfg_index;
  logic [5:0]            cfg_wdata;

  lcd_beat_t  expected_beats[$];
  int         errors = 0;
  bit         quiet = 1'b0;
  int         sink_hold = 0;

  logic [5:0] cfg_width = clntw_pkg::LINE_WIDTH_RST;
  logic [2:0] cfg_lines = clntw_pkg::LINE_COUNT_RST;
  logic       cfg_wrap = clntw_pkg::WRAP_ENABLE_RST;
  logic       cfg_backlight = clntw_pkg::BACKLIGHT_ON_RST;
  logic [7:0] cur_col = 8'd0;
  logic [7:0] cur_row = 8'd0;

  char_lcd_nibble_text_writer_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_char_code   (in_char_code),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_bus_byte   (out_bus_byte),
    .out_last_of_run(out_last_of_run),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic void queue_nibble(logic [3:0] nib, logic rs);
    logic [7:0] b;
    b = {nib, cfg_backlight, 2'b00, rs};
    expected_beats.push_back(lcd_beat_t'{b | LCD_EN, 1'b0});
    expected_beats.push_back(lcd_beat_t'{b, 1'b0});
  endfunction

  function automatic void queue_byte(logic [7:0] v, logic rs);
    queue_nibble(v[7:4], rs);
    queue_nibble(v[3:0], rs);
  endfunction

  function automatic void queue_cursor_move(logic [7:0] x, logic [7:0] y);
    logic [7:0] base;
    if (cfg_wrap) begin
      if (x >= {2'b00, cfg_width}) x = 8'd0;
      if (y >= {5'b00000, cfg_lines}) y = 8'd0;
    end
    cur_col = x;
    cur_row = y;
    case (y)
      8'd0: base = clntw_pkg::ROW0_BASE;
      8'd1: base = clntw_pkg::ROW1_BASE;
      8'd2: base = clntw_pkg::ROW2_BASE;
      8'd3: base = clntw_pkg::ROW3_BASE;
      default: return;
    endcase
    queue_byte((base + x) | clntw_pkg::CMD_DDRAM, clntw_pkg::RS_CMD);
  endfunction

  function automatic void predict_char(logic [7:0] code);
    int        mark;
    lcd_beat_t tail;
    mark = expected_beats.size();
    if (code == clntw_pkg::CHAR_CR) begin
      queue_cursor_move(8'd0, cur_row);
    end else if (code == clntw_pkg::CHAR_LF) begin
      cur_row = cur_row + 8'd1;
      queue_cursor_move(cur_col, cur_row);
    end else if (code == clntw_pkg::CHAR_FF) begin
      queue_byte(clntw_pkg::CMD_CLEAR, clntw_pkg::RS_CMD);
      cur_col = 8'd0;
      cur_row = 8'd0;
    end else begin
      queue_byte(code, clntw_pkg::RS_DATA);
      cur_col = cur_col + 8'd1;
      if (cfg_wrap && cur_col >= {2'b00, cfg_width}) begin
        cur_col = 8'd0;
        cur_row = cur_row + 8'd1;
        if (cur_row >= {5'b00000, cfg_lines}) cur_row = 8'd0;
        queue_cursor_move(cur_col, cur_row);
      end
    end
    if (expected_beats.size() > mark) begin
      tail = expected_beats.pop_back();
      tail.last_of_run = 1'b1;
      expected_beats.push_back(tail);
    end
  endfunction

  function automatic logic [7:0] random_char();
    case ($urandom_range(0, 19))
      0, 1:    return clntw_pkg::CHAR_CR;
      2, 3:    return clntw_pkg::CHAR_LF;
      4:       return clntw_pkg::CHAR_FF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_char(input logic [7:0] code);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push      <= 1'b1;
    in_char_code <= code;
    do @(posedge clk); while (in_full);
    predict_char(code);
  endtask

  task automatic drain_display();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input clntw_pkg::reg_idx_t idx, input logic [5:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      clntw_pkg::REG_LINE_WIDTH:   cfg_width = val;
      clntw_pkg::REG_LINE_COUNT:   cfg_lines = val[2:0];
      clntw_pkg::REG_WRAP_ENABLE:  cfg_wrap = val[0];
      clntw_pkg::REG_BACKLIGHT_ON: cfg_backlight = val[0];
      default:                     cfg_width = cfg_width;
    endcase
  endtask

  task automatic set_geometry(input logic [5:0] width, input logic [2:0] lines,
                              input logic wrap, input logic backlight);
    write_reg(clntw_pkg::REG_LINE_WIDTH, width);
    write_reg(clntw_pkg::REG_LINE_COUNT, {3'b000, lines});
    write_reg(clntw_pkg::REG_WRAP_ENABLE, {5'b00000, wrap});
    write_reg(clntw_pkg::REG_BACKLIGHT_ON, {5'b00000, backlight});
  endtask

  task automatic test_control_codes();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h41);
    send_char(clntw_pkg::CHAR_CR);
    send_char(clntw_pkg::CHAR_LF);
    send_char(clntw_pkg::CHAR_LF);
    send_char(8'h0B);
    send_char(8'h0E);
    send_char(8'h80);
    send_char(8'h7F);
    send_char(clntw_pkg::CHAR_FF);
    drain_display();
  endtask

  task automatic test_geometry_extremes();
    set_geometry(6'd1, 3'd1, 1'b1, 1'b0);
    send_char(8'h55);
    send_char(8'hAA);
    send_char(clntw_pkg::CHAR_LF);
    drain_display();
    set_geometry(6'd0, 3'd0, 1'b1, 1'b1);
    send_char(8'h30);
    send_char(clntw_pkg::CHAR_LF);
    send_char(8'h31);
    drain_display();
  endtask

  task automatic test_wrap_disabled();
    set_geometry(6'd40, 3'd4, 1'b0, 1'b1);
    repeat (5) send_char(clntw_pkg::CHAR_LF);
    send_char(clntw_pkg::CHAR_CR);
    send_char(8'h61);
    send_char(clntw_pkg::CHAR_FF);
    drain_display();
    set_geometry(6'd63, 3'd7, 1'b1, 1'b0);
    repeat (5) send_char(clntw_pkg::CHAR_LF);
    drain_display();
  endtask

  task automatic test_position_overrun();
    set_geometry(6'd16, 3'd2, 1'b0, 1'b1);
    send_char(clntw_pkg::CHAR_FF);
    repeat (40) send_char(8'($urandom_range(16, 255)));
    repeat (3) send_char(clntw_pkg::CHAR_LF);
    repeat (20) send_char(8'($urandom_range(16, 255)));
    send_char(clntw_pkg::CHAR_CR);
    repeat (6) send_char(clntw_pkg::CHAR_LF);
    drain_display();
  endtask

  task automatic test_backpressure();
    set_geometry(6'd2, 3'd3, 1'b1, 1'b1);
    quiet = 1'b1;
    sink_hold = 80;
    repeat (20) send_char(8'($urandom_range(0, 255)));
    quiet = 1'b0;
    drain_display();
  endtask

  task automatic test_random_streams(input int phases, input int per_phase);
    logic [5:0] width;
    repeat (phases) begin
      case ($urandom_range(0, 4))
        0:       width = 6'd1;
        1:       width = 6'd0;
        2:       width = 6'($urandom_range(2, 8));
        3:       width = 6'd40;
        default: width = 6'($urandom_range(0, 63));
      endcase
      set_geometry(width, 3'($urandom_range(0, 7)), $urandom_range(0, 3) != 0,
                   1'($urandom_range(0, 1)));
      repeat (per_phase) send_char(random_char());
      drain_display();
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        out_pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    lcd_beat_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_beats.size() == 0) begin
        $error("out_bus_byte: no item expected, got %h", out_bus_byte);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (out_bus_byte !== want.bus_byte) begin
          $error("out_bus_byte: expected %h, got %h", want.bus_byte, out_bus_byte);
          errors++;
        end
        if (out_last_of_run !== want.last_of_run) begin
          $error("out_last_of_run: expected %b, got %b", want.last_of_run, out_last_of_run);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_char_code = 8'h00;
    cfg_we       = 1'b0;
    cfg_index    = clntw_pkg::REG_LINE_WIDTH;
    cfg_wdata    = 6'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_control_codes();
    test_geometry_extremes();
    test_wrap_disabled();
    test_position_overrun();
    test_backpressure();
    test_random_streams(4, 15);
    quiet = 1'b1;
    test_random_streams(1, 16);

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
